@@ rtl/b64d_pkg.sv @@
// Shared types, constants and decode functions of the Base64 stream decoder.
package b64d_pkg;

	localparam int B64D_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SLASH   = 8'h2f;

	localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SEXTET_PLUS       = 6'd62;
	localparam logic [5:0] SEXTET_SLASH      = 6'd63;

	localparam logic [1:0] HELD_FULL = 2'd3;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       has_byte;
		logic       last_of_run;
		logic       string_done;
	} out_item_t;

	// One queued run: up to three bytes caused by a single input item.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            has_byte;
		logic            done;
	} run_t;

	typedef struct packed {
		logic       invalid;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(logic [7:0] ch);
		sextet_t s;
		s.invalid = 1'b0;
		s.value   = '0;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			s.value = 6'(ch - CH_UPPER_A);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			s.value = 6'(ch - CH_LOWER_A) + SEXTET_LOWER_BASE;
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			s.value = 6'(ch - CH_DIGIT_0) + SEXTET_DIGIT_BASE;
		end else if (ch == CH_PLUS) begin
			s.value = SEXTET_PLUS;
		end else if (ch == CH_SLASH) begin
			s.value = SEXTET_SLASH;
		end else begin
			s.invalid = 1'b1;
		end
		return s;
	endfunction

	function automatic logic [2:0][7:0] make_bytes(logic [5:0] s0, logic [5:0] s1,
			logic [5:0] s2, logic [5:0] s3);
		logic [2:0][7:0] b;
		b[0] = {s0, s1[5:4]};
		b[1] = {s1[3:0], s2[5:2]};
		b[2] = {s2[1:0], s3};
		return b;
	endfunction

endpackage

@@ rtl/b64d_front.sv @@
// Front end: classifies chars, holds sextets, forms at most one run per item.
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  b64d_pkg::in_item_t item,
	output logic              run_valid,
	output b64d_pkg::run_t    run
);
	import b64d_pkg::*;

	logic [1:0] held_count_q;
	logic       stopped_q;
	logic [5:0] held_q [3];

	sextet_t    sx;
	logic       grp, stop, wr, eos;
	logic [1:0] flush_cnt;
	logic [1:0] flush_bytes;
	logic [5:0] fs [3];

	always_comb begin
		sx   = sextet_of(item.char_in);
		eos  = item.end_of_string;
		grp  = !stopped_q && !sx.invalid && held_count_q == HELD_FULL;
		stop = !stopped_q && sx.invalid;
		wr   = !stopped_q && !sx.invalid && held_count_q != HELD_FULL;

		fs[0] = held_q[0];
		fs[1] = held_q[1];
		fs[2] = held_q[2];
		if (wr) begin
			fs[held_count_q] = sx.value;
		end

		if (stop) begin
			flush_cnt = held_count_q;
		end else if (wr && eos) begin
			flush_cnt = held_count_q + 2'd1;
		end else begin
			flush_cnt = 2'd0;
		end
		flush_bytes = (flush_cnt >= 2'd2) ? flush_cnt - 2'd1 : 2'd0;

		run.done     = eos;
		run.has_byte = 1'b1;
		if (grp) begin
			run.bytes    = make_bytes(held_q[0], held_q[1], held_q[2], sx.value);
			run.last_idx = 2'd2;
		end else if (flush_bytes != 2'd0) begin
			run.bytes    = make_bytes(fs[0], fs[1], fs[2], 6'd0);
			run.last_idx = flush_bytes - 2'd1;
		end else begin
			run.bytes    = '0;
			run.last_idx = 2'd0;
			run.has_byte = 1'b0;
		end
		run_valid = accept && (grp || flush_bytes != 2'd0 || eos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			stopped_q    <= 1'b0;
		end else if (accept) begin
			if (eos) begin
				held_count_q <= '0;
				stopped_q    <= 1'b0;
			end else if (grp) begin
				held_count_q <= '0;
			end else if (stop) begin
				held_count_q <= '0;
				stopped_q    <= 1'b1;
			end else if (wr) begin
				held_count_q <= held_count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr) begin
			held_q[held_count_q] <= sx.value;
		end
	end

endmodule

@@ rtl/b64d_queue.sv @@
// Short run queue that decouples the front end from the byte serialiser.
module b64d_queue #(
	parameter int Depth = b64d_pkg::B64D_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  b64d_pkg::run_t wr_data,
	input  logic           rd_en,
	output logic           rd_valid,
	output b64d_pkg::run_t rd_data,
	output logic           full
);
	import b64d_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	run_t            entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign rd_valid = count_q != '0;
	assign full     = count_q == DepthCnt;
	assign rd_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/b64d_back.sv @@
// Back end: splits queued runs into single results behind an output register.
module b64d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              run_valid,
	input  b64d_pkg::run_t    run,
	output logic              run_pop,
	input  logic              pop,
	output logic              empty,
	output b64d_pkg::out_item_t result
);
	import b64d_pkg::*;

	logic       out_valid_q;
	out_item_t  out_q;
	logic [1:0] idx_q;
	logic       load, last;
	logic [7:0] sel_byte;

	assign load    = !out_valid_q || pop;
	assign last    = idx_q == run.last_idx;
	assign run_pop = load && run_valid && last;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = run.bytes[0];
			2'd1:    sel_byte = run.bytes[1];
			2'd2:    sel_byte = run.bytes[2];
			default: sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= run_valid;
			if (run_valid) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && run_valid) begin
			out_q.byte_out    <= sel_byte;
			out_q.has_byte    <= run.has_byte;
			out_q.last_of_run <= last;
			out_q.string_done <= last && run.done;
		end
	end

endmodule

@@ rtl/base64_stream_decoder.sv @@
// Top level of the streaming Base64 decoder (RFC 4648 alphabet).
//
//   Channel   Handshake        Payload   Transfer when
//   input     push / full      item      push high and full low
//   result    empty / pop      result    pop high and empty low
//
// The input side takes one character in every cycle while the run queue has
// room; the front end decodes it in the cycle of the transfer. A result leaves
// at most one a cycle through the output register, so an item that yields
// three bytes occupies the back end for three results, and the queue depth
// (QueueDepth runs) sets how far the front end may run ahead of it.
// An input transfer passes the run queue and the output register before its
// first result appears. The asynchronous reset clears the held count, the stop
// flag, the queue pointers and count, the byte index and the output valid
// flag; no clearing pass is needed. A stall on the result side fills the queue
// and then raises full; a stall on the input side simply lets the queue drain.
module base64_stream_decoder #(
	parameter int QueueDepth = b64d_pkg::B64D_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  b64d_pkg::in_item_t  item,
	input  logic                pop,
	output logic                empty,
	output b64d_pkg::out_item_t result
);
	import b64d_pkg::*;

	logic accept;
	logic front_valid;
	run_t front_run;
	logic queue_valid;
	run_t queue_run;
	logic queue_pop;

	// An item is only taken when the queue can hold whatever run it causes.
	assign accept = push && !full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.run_valid (front_valid),
		.run       (front_run)
	);

	b64d_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_data  (front_run),
		.rd_en    (queue_pop),
		.rd_valid (queue_valid),
		.rd_data  (queue_run),
		.full     (full)
	);

	// The back end steps through the bytes of the oldest run and releases the
	// run from the queue once its final result has been loaded for output.
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (queue_valid),
		.run       (queue_run),
		.run_pop   (queue_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of the Base64 stream decoder: directed table, random strings, predictor.
module testbench;
	import b64d_pkg::*;

	// A row of stimulus. Where typed is set, want is the single result that the
	// row must produce; otherwise the predictor works out what is due.
	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
		logic       typed;
		out_item_t  want;
	} stim_row_t;

	// Results that can be read straight off the decoding rules.
	localparam out_item_t NO_RESULT = '0;
	localparam out_item_t END_MARK  = '{8'h00, 1'b0, 1'b1, 1'b1};
	localparam out_item_t BYTE_FF   = '{8'hff, 1'b1, 1'b1, 1'b0};

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 96;
	localparam int DRAIN_CYCLES  = 20;

	// Directed part: extremes of the character code, padding, invalid
	// characters, a lone held sextet, characters after a stop, full quads and
	// the two- and three-sextet flushes at a stop, the latter also at string end.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'hff, 1'b1, 1'b1, END_MARK},   // high-bit character on its own
		'{"=",   1'b1, 1'b1, END_MARK},   // padding on its own
		'{"A",   1'b1, 1'b1, END_MARK},   // one held sextet gives no byte
		'{"/",   1'b0, 1'b0, NO_RESULT},
		'{"/",   1'b0, 1'b0, NO_RESULT},
		'{"=",   1'b0, 1'b1, BYTE_FF},    // two held sextets flushed by padding
		'{8'h80, 1'b0, 1'b0, NO_RESULT},  // ignored after the stop
		'{"z",   1'b1, 1'b1, END_MARK},   // ignored, but still closes the string
		'{"T",   1'b0, 1'b0, NO_RESULT},
		'{"W",   1'b0, 1'b0, NO_RESULT},
		'{"F",   1'b0, 1'b0, NO_RESULT},
		'{"u",   1'b0, 1'b0, NO_RESULT},
		'{"+",   1'b0, 1'b0, NO_RESULT},
		'{"/",   1'b0, 1'b0, NO_RESULT},
		'{"0",   1'b0, 1'b0, NO_RESULT},
		'{"9",   1'b1, 1'b0, NO_RESULT},  // quad released together with the end mark
		'{"a",   1'b0, 1'b0, NO_RESULT},
		'{"Z",   1'b0, 1'b0, NO_RESULT},
		'{"+",   1'b1, 1'b0, NO_RESULT},  // three held sextets flushed at the end
		'{8'h00, 1'b1, 1'b1, END_MARK},   // lowest code, nothing held
		'{"Q",   1'b0, 1'b0, NO_RESULT},
		'{"k",   1'b0, 1'b0, NO_RESULT},
		'{"/",   1'b0, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, 1'b0, NO_RESULT},  // lowest high-bit code flushes two bytes
		'{"=",   1'b1, 1'b1, END_MARK}
	};

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  item   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	// Decoder state as the predictor sees it.
	logic [1:0] held_n = '0;
	logic [5:0] held_sx [3] = '{default: '0};
	logic       halted = 1'b0;

	out_item_t  due_results[$];
	int         mismatches = 0;
	logic       fed_all = 1'b0;

	base64_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always #1 clk = ~clk;

	// The predictor's flush: two held sextets give one byte, three give two,
	// and a single one gives nothing. Unheld sextets count as zero.
	function automatic void flush_held(ref out_item_t res[$]);
		logic [5:0] s0, s1, s2;
		s0 = (held_n > 2'd0) ? held_sx[0] : 6'd0;
		s1 = (held_n > 2'd1) ? held_sx[1] : 6'd0;
		s2 = (held_n > 2'd2) ? held_sx[2] : 6'd0;
		if (held_n >= 2'd2) begin
			res.push_back('{{s0, s1[5:4]}, 1'b1, 1'b0, 1'b0});
		end
		if (held_n == HELD_FULL) begin
			res.push_back('{{s1[3:0], s2[5:2]}, 1'b1, 1'b0, 1'b0});
		end
		held_n = 2'd0;
	endfunction

	// Works out the results of one accepted character and advances the state.
	function automatic void decode_char(input in_item_t it, ref out_item_t res[$]);
		logic [5:0] v;
		logic       bad;
		out_item_t  tail;
		v   = 6'd0;
		bad = 1'b0;
		if (!halted) begin
			if (it.char_in >= CH_UPPER_A && it.char_in <= CH_UPPER_Z) begin
				v = 6'(it.char_in - CH_UPPER_A);
			end else if (it.char_in >= CH_LOWER_A && it.char_in <= CH_LOWER_Z) begin
				v = 6'(it.char_in - CH_LOWER_A) + SEXTET_LOWER_BASE;
			end else if (it.char_in >= CH_DIGIT_0 && it.char_in <= CH_DIGIT_9) begin
				v = 6'(it.char_in - CH_DIGIT_0) + SEXTET_DIGIT_BASE;
			end else if (it.char_in == CH_PLUS) begin
				v = SEXTET_PLUS;
			end else if (it.char_in == CH_SLASH) begin
				v = SEXTET_SLASH;
			end else begin
				bad = 1'b1;
			end
			if (bad) begin
				// Padding and every other stranger stop decoding for the rest of the string.
				halted = 1'b1;
				flush_held(res);
			end else if (held_n == HELD_FULL) begin
				res.push_back('{{held_sx[0], held_sx[1][5:4]}, 1'b1, 1'b0, 1'b0});
				res.push_back('{{held_sx[1][3:0], held_sx[2][5:2]}, 1'b1, 1'b0, 1'b0});
				res.push_back('{{held_sx[2][1:0], v}, 1'b1, 1'b0, 1'b0});
				held_n = 2'd0;
			end else begin
				held_sx[held_n] = v;
				held_n = held_n + 2'd1;
			end
		end
		if (it.end_of_string) begin
			flush_held(res);
			if (res.size() == 0) begin
				res.push_back(NO_RESULT);
			end
			tail = res.pop_back();
			tail.string_done = 1'b1;
			res.push_back(tail);
			halted = 1'b0;
		end
		if (res.size() != 0) begin
			tail = res.pop_back();
			tail.last_of_run = 1'b1;
			res.push_back(tail);
		end
	endfunction

	task automatic report(input string what, input logic [10:0] got, input logic [10:0] want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (due_results.size() == 0) begin
			report("result with nothing due", got, '0);
			return;
		end
		want = due_results.pop_front();
		if (got.byte_out !== want.byte_out) begin
			report("byte_out", 11'(got.byte_out), 11'(want.byte_out));
		end
		if (got.has_byte !== want.has_byte) begin
			report("has_byte", 11'(got.has_byte), 11'(want.has_byte));
		end
		if (got.last_of_run !== want.last_of_run) begin
			report("last_of_run", 11'(got.last_of_run), 11'(want.last_of_run));
		end
		if (got.string_done !== want.string_done) begin
			report("string_done", 11'(got.string_done), 11'(want.string_done));
		end
	endtask

	// Sender. The stimulus is built up front: the directed table, then random
	// strings. Most strings are well formed (alphabet characters, often a whole
	// number of quads) with padding or junk now and then; the rest is raw noise
	// over all 256 codes, which may or may not close its string. Items go out
	// in bursts of random length with random gaps, and push stays high on an
	// offered item until its transfer.
	initial begin : feed
		stim_row_t   rows[$];
		out_item_t   scratch[$];
		logic [7:0]  seg[$];
		logic [5:0]  v;
		logic [7:0]  ch;
		logic        noisy;
		logic        closes;
		int          counted;
		int          len;
		int          idx;
		int          burst_left;
		int          gap_left;
		logic        go;

		foreach (DIRECTED[k]) begin
			rows.push_back(DIRECTED[k]);
		end
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			seg   = {};
			noisy = ($urandom_range(0, 4) == 0);
			if (noisy) begin
				len = $urandom_range(1, 5);
				repeat (len) seg.push_back(8'($urandom_range(0, 255)));
				closes = $urandom_range(0, 1);
			end else begin
				len = ($urandom_range(0, 2) == 0) ? 4 * $urandom_range(1, 3)
					: $urandom_range(0, 14);
				repeat (len) begin
					v = 6'($urandom_range(0, 63));
					if (v < SEXTET_LOWER_BASE) begin
						ch = CH_UPPER_A + 8'(v);
					end else if (v < SEXTET_DIGIT_BASE) begin
						ch = CH_LOWER_A + 8'(v - SEXTET_LOWER_BASE);
					end else if (v < SEXTET_PLUS) begin
						ch = CH_DIGIT_0 + 8'(v - SEXTET_DIGIT_BASE);
					end else if (v == SEXTET_PLUS) begin
						ch = CH_PLUS;
					end else begin
						ch = CH_SLASH;
					end
					seg.push_back(ch);
				end
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 2)) seg.push_back("=");
				end
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom_range(0, 255)));
				end
				closes = ($urandom_range(0, 7) != 0);
			end
			if (seg.size() == 0) begin
				seg.push_back(8'($urandom_range(0, 255)));
			end
			foreach (seg[k]) begin
				rows.push_back('{seg[k], closes && (k == seg.size() - 1), 1'b0, NO_RESULT});
			end
			counted += len + 1;
		end

		idx        = 0;
		burst_left = 0;
		gap_left   = 0;
		wait (arst_n);
		while (idx < rows.size()) begin
			@(posedge clk);
			if (push && !full) begin
				scratch = {};
				decode_char('{rows[idx].ch, rows[idx].eos}, scratch);
				if (rows[idx].typed) begin
					due_results.push_back(rows[idx].want);
				end else begin
					foreach (scratch[k]) due_results.push_back(scratch[k]);
				end
				idx++;
			end
			if (push && full) begin
				go = 1'b1;
			end else if (idx == rows.size()) begin
				go = 1'b0;
			end else begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (burst_left > 0) begin
					go = 1'b1;
					burst_left--;
				end else begin
					go = 1'b0;
					gap_left--;
				end
			end
			push <= go;
			if (go) begin
				item <= '{rows[idx].ch, rows[idx].eos};
			end
		end
		fed_all = 1'b1;
	end

	// Receiver. After each pass over its 16-bit map it picks a fresh pop pattern:
	// always ready, random, mostly stalled, or half stalled and half ready, so that
	// stalls land on every cycle of a multi-byte run and also let the queue fill up.
	initial begin : drain
		logic [15:0] pop_map;
		int          ph;
		pop_map = '1;
		ph      = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_result(result);
			end
			if (ph == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						pop_map = '1;
					end
					1: begin
						pop_map = 16'($urandom);
					end
					2: begin
						pop_map = 16'($urandom & $urandom);
					end
					default: begin
						pop_map = 16'h00ff;
					end
				endcase
			end
			pop <= pop_map[ph];
			ph = (ph + 1) % 16;
		end
	end

	// Reset once, then wait for the sender to finish and for every due result
	// to arrive. A drain wait then catches any stray result before the verdict.
	initial begin : run
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (fed_all);
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// The timeout lies far beyond the length of a correct run.
	initial begin : watchdog
		#400000;
		$display("testbench failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
dv/testbench.sv
